### rtl/mos6502_core_bus_stepper_assert.svh
// Assertion macros for the 6502 bus stepper.
// Used by the top level; no other dependencies.
`ifndef MOS6502_CORE_BUS_STEPPER_ASSERT_SVH
`define MOS6502_CORE_BUS_STEPPER_ASSERT_SVH

// same-cycle implication
`define M65_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define M65_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/m65_pkg.sv
// Shared types, codes and helper functions for the 6502 bus stepper.
// No dependencies.
package m65_pkg;

   typedef enum logic [4:0] {
      PH_VEC_LO = 5'd0, PH_VEC_HI = 5'd1, PH_FETCH = 5'd2, PH_INT = 5'd3,
      PH_OP1 = 5'd4, PH_OP2 = 5'd5, PH_PTR_LO = 5'd6, PH_PTR_HI = 5'd7,
      PH_DATA = 5'd8, PH_J_LO = 5'd9, PH_J_HI = 5'd10, PH_JI_LO = 5'd11,
      PH_JI_HI = 5'd12, PH_BR = 5'd13, PH_PULL = 5'd14, PH_RTS_LO = 5'd15,
      PH_RTS_HI = 5'd16, PH_RTI_P = 5'd17, PH_RTI_LO = 5'd18, PH_RTI_HI = 5'd19,
      PH_SPARE0 = 5'd20, PH_SPARE1 = 5'd21, PH_SPARE2 = 5'd22, PH_SPARE3 = 5'd23,
      PH_SPARE4 = 5'd24, PH_SPARE5 = 5'd25, PH_SPARE6 = 5'd26, PH_SPARE7 = 5'd27,
      PH_SPARE8 = 5'd28, PH_SPARE9 = 5'd29, PH_SPARE10 = 5'd30, PH_SPARE11 = 5'd31
   } phase_type;

   typedef enum logic [3:0] {
      M_IMM = 4'd0, M_ZP = 4'd1, M_ZPX = 4'd2, M_ZPY = 4'd3, M_ABS = 4'd4,
      M_ABX = 4'd5, M_ABY = 4'd6, M_IZX = 4'd7, M_IZY = 4'd8, M_BAD = 4'd9
   } mode_type;

   // operation kinds
   localparam logic [4:0] K_ORA = 5'd0, K_AND = 5'd1, K_EOR = 5'd2, K_ADC = 5'd3;
   localparam logic [4:0] K_STA = 5'd4, K_LDA = 5'd5, K_CMP = 5'd6, K_SBC = 5'd7;
   localparam logic [4:0] K_ASL = 5'd8, K_ROL = 5'd9, K_LSR = 5'd10, K_ROR = 5'd11;
   localparam logic [4:0] K_STX = 5'd12, K_LDX = 5'd13, K_DEC = 5'd14, K_INC = 5'd15;
   localparam logic [4:0] K_BIT = 5'd16, K_STY = 5'd17, K_LDY = 5'd18, K_CPY = 5'd19;
   localparam logic [4:0] K_CPX = 5'd20, K_NONE = 5'd0;

   localparam logic [15:0] VEC_NMI = 16'hFFFA;
   localparam logic [15:0] VEC_RES = 16'hFFFC;
   localparam logic [15:0] VEC_IRQ = 16'hFFFE;
   localparam logic [7:0]  STACK_PAGE = 8'h01;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  index_x;
      logic [7:0]  index_y;
      logic [7:0]  stack_ptr;
      logic [15:0] prog_counter;
      logic [7:0]  status_flags;
      phase_type   seq_phase;
      logic [7:0]  opcode_latch;
      logic [15:0] addr_temp;
      logic        nmi_pending;
   } cpu_state_type;

   localparam cpu_state_type CPU_RESET = '{
      acc: 8'h00, index_x: 8'h00, index_y: 8'h00, stack_ptr: 8'hFF,
      prog_counter: 16'h0000, status_flags: 8'h04, seq_phase: PH_VEC_LO,
      opcode_latch: 8'h00, addr_temp: 16'h0000, nmi_pending: 1'b0};

   typedef struct packed {
      logic [15:0] bus_address;
      logic        bus_write;
      logic [7:0]  write_data;
      logic        last;
   } bus_res_type;

   typedef bus_res_type [3:0] res_list_type;

   typedef struct packed {
      mode_type   mode;
      logic [4:0] kind;
   } decode_type;

   function automatic bus_res_type mk_rd(logic [15:0] a);
      return '{bus_address: a, bus_write: 1'b0, write_data: 8'h00, last: 1'b1};
   endfunction

   function automatic bus_res_type mk_wr(logic [15:0] a, logic [7:0] d);
      return '{bus_address: a, bus_write: 1'b1, write_data: d, last: 1'b0};
   endfunction

   function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
      return {v[7], p[6:2], (v == 8'h00), p[0]};
   endfunction

   function automatic decode_type decode(logic [7:0] op);
      logic [1:0] cc;
      logic [2:0] aaa;
      logic [2:0] bbb;
      decode_type r;
      cc  = op[1:0];
      aaa = op[7:5];
      bbb = op[4:2];
      r.kind = K_NONE;
      r.mode = M_BAD;
      if (cc == 2'd1) begin
         r.kind = {2'b00, aaa};
         case (bbb)
            3'd0: r.mode = M_IZX;
            3'd1: r.mode = M_ZP;
            3'd2: r.mode = (op == 8'h89) ? M_BAD : M_IMM;
            3'd3: r.mode = M_ABS;
            3'd4: r.mode = M_IZY;
            3'd5: r.mode = M_ZPX;
            3'd6: r.mode = M_ABY;
            default: r.mode = M_ABX;
         endcase
      end else if (cc == 2'd2) begin
         r.kind = 5'd8 + {2'b00, aaa};
         case (bbb)
            3'd0: r.mode = (op == 8'hA2) ? M_IMM : M_BAD;
            3'd1: r.mode = M_ZP;
            3'd3: r.mode = M_ABS;
            3'd5: r.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
            3'd7: r.mode = (aaa == 3'd5) ? M_ABY : ((aaa == 3'd4) ? M_BAD : M_ABX);
            default: r.mode = M_BAD;
         endcase
      end else if (cc == 2'd0 && aaa != 3'd0 && aaa != 3'd2 && aaa != 3'd3) begin
         case (aaa)
            3'd1: r.kind = K_BIT;
            3'd4: r.kind = K_STY;
            3'd5: r.kind = K_LDY;
            3'd6: r.kind = K_CPY;
            default: r.kind = K_CPX;
         endcase
         case (bbb)
            3'd0: r.mode = (aaa >= 3'd5) ? M_IMM : M_BAD;
            3'd1: r.mode = M_ZP;
            3'd3: r.mode = M_ABS;
            3'd5: r.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPX : M_BAD;
            3'd7: r.mode = (aaa == 3'd5) ? M_ABX : M_BAD;
            default: r.mode = M_BAD;
         endcase
      end
      return r;
   endfunction

endpackage

### rtl/m65_step.sv
// One bus step of the 6502 core: next architectural state and the bus
// accesses caused by one transaction. Depends on m65_pkg.
module m65_step (
   input  m65_pkg::cpu_state_type cur_state,
   input  logic                   op,
   input  logic [7:0]             read_data,
   input  logic                   irq_level,
   input  logic                   nmi_pulse,
   output m65_pkg::cpu_state_type nxt_state,
   output m65_pkg::res_list_type  res,
   output logic [2:0]             res_count
);
   import m65_pkg::*;

   function automatic cpu_state_type adc(cpu_state_type s, logic [7:0] m);
      logic [8:0] sum;
      logic [7:0] r;
      sum = {1'b0, s.acc} + {1'b0, m} + {8'h00, s.status_flags[0]};
      r = sum[7:0];
      s.status_flags[0] = sum[8];
      s.status_flags[6] = ((s.acc ^ r) & (m ^ r) & 8'h80) != 8'h00;
      s.acc = r;
      s.status_flags = set_nz(s.status_flags, r);
      return s;
   endfunction

   function automatic logic [7:0] cmp(logic [7:0] p, logic [7:0] a, logic [7:0] b);
      logic [7:0] q;
      q = set_nz(p, a - b);
      q[0] = (a >= b);
      return q;
   endfunction

   function automatic cpu_state_type do_read(cpu_state_type s, logic [4:0] k, logic [7:0] m);
      case (k)
         K_ORA: begin s.acc = s.acc | m; s.status_flags = set_nz(s.status_flags, s.acc); end
         K_AND: begin s.acc = s.acc & m; s.status_flags = set_nz(s.status_flags, s.acc); end
         K_EOR: begin s.acc = s.acc ^ m; s.status_flags = set_nz(s.status_flags, s.acc); end
         K_ADC: s = adc(s, m);
         K_LDA: begin s.acc = m; s.status_flags = set_nz(s.status_flags, m); end
         K_CMP: s.status_flags = cmp(s.status_flags, s.acc, m);
         K_SBC: s = adc(s, ~m);
         K_LDX: begin s.index_x = m; s.status_flags = set_nz(s.status_flags, m); end
         K_BIT: s.status_flags = {m[7:6], s.status_flags[5:2], ((s.acc & m) == 8'h00),
                                  s.status_flags[0]};
         K_LDY: begin s.index_y = m; s.status_flags = set_nz(s.status_flags, m); end
         K_CPY: s.status_flags = cmp(s.status_flags, s.index_y, m);
         K_CPX: s.status_flags = cmp(s.status_flags, s.index_x, m);
         default: ;
      endcase
      return s;
   endfunction

   // returns {carry, result}
   function automatic logic [8:0] shf(logic [4:0] k, logic [7:0] v, logic cin);
      case (k)
         K_ASL:   return {v[7], v[6:0], 1'b0};
         K_ROL:   return {v[7], v[6:0], cin};
         K_LSR:   return {v[0], 1'b0, v[7:1]};
         default: return {v[0], cin, v[7:1]};
      endcase
   endfunction

   always_comb begin
      cpu_state_type s;
      res_list_type  r;
      logic [2:0]    n;
      decode_type    dc;
      logic          bnd;
      logic          eff;
      logic [15:0]   ea;
      logic [8:0]    sr;
      logic [7:0]    d;
      logic [7:0]    t;
      logic          taken;
      s   = cur_state;
      r   = '0;
      n   = 3'd0;
      bnd = 1'b0;
      eff = 1'b0;
      ea  = 16'h0000;
      d   = read_data;
      dc  = decode(s.opcode_latch);
      sr  = 9'h000;
      t   = 8'h00;
      taken = 1'b0;
      if (!op) begin
         s = CPU_RESET;
         r[0] = mk_rd(VEC_RES);
         n = 3'd1;
      end else begin
         if (nmi_pulse) s.nmi_pending = 1'b1;
         unique case (s.seq_phase)
            PH_VEC_LO: begin
               s.prog_counter[7:0] = d;
               r[0] = mk_rd((s.addr_temp == VEC_NMI || s.addr_temp == VEC_IRQ) ?
                            s.addr_temp + 16'd1 : VEC_RES + 16'd1);
               n = 3'd1;
               s.seq_phase = PH_VEC_HI;
            end
            PH_VEC_HI: begin
               s.prog_counter[15:8] = d;
               bnd = 1'b1;
            end
            PH_FETCH: begin
               s.opcode_latch = d;
               s.prog_counter = s.prog_counter + 16'd1;
               dc = decode(d);
               case (d)
                  8'h00: begin
                     s.prog_counter = s.prog_counter + 16'd1;
                     r[0] = mk_wr({STACK_PAGE, s.stack_ptr}, s.prog_counter[15:8]);
                     r[1] = mk_wr({STACK_PAGE, s.stack_ptr - 8'd1}, s.prog_counter[7:0]);
                     r[2] = mk_wr({STACK_PAGE, s.stack_ptr - 8'd2}, s.status_flags | 8'h30);
                     s.stack_ptr = s.stack_ptr - 8'd3;
                     s.status_flags[2] = 1'b1;
                     s.addr_temp = VEC_IRQ;
                     r[3] = mk_rd(VEC_IRQ);
                     n = 3'd4;
                     s.seq_phase = PH_VEC_LO;
                  end
                  8'h20, 8'h4C, 8'h6C: begin
                     r[0] = mk_rd(s.prog_counter); n = 3'd1; s.seq_phase = PH_J_LO;
                  end
                  8'h40, 8'h60, 8'h28, 8'h68: begin
                     s.stack_ptr = s.stack_ptr + 8'd1;
                     r[0] = mk_rd({STACK_PAGE, s.stack_ptr});
                     n = 3'd1;
                     s.seq_phase = (d == 8'h40) ? PH_RTI_P :
                                   ((d == 8'h60) ? PH_RTS_LO : PH_PULL);
                  end
                  8'h08, 8'h48: begin
                     r[0] = mk_wr({STACK_PAGE, s.stack_ptr},
                                  (d == 8'h08) ? (s.status_flags | 8'h30) : s.acc);
                     n = 3'd1;
                     s.stack_ptr = s.stack_ptr - 8'd1;
                     bnd = 1'b1;
                  end
                  8'h88: begin
                     s.index_y = s.index_y - 8'd1;
                     s.status_flags = set_nz(s.status_flags, s.index_y); bnd = 1'b1;
                  end
                  8'hC8: begin
                     s.index_y = s.index_y + 8'd1;
                     s.status_flags = set_nz(s.status_flags, s.index_y); bnd = 1'b1;
                  end
                  8'hCA: begin
                     s.index_x = s.index_x - 8'd1;
                     s.status_flags = set_nz(s.status_flags, s.index_x); bnd = 1'b1;
                  end
                  8'hE8: begin
                     s.index_x = s.index_x + 8'd1;
                     s.status_flags = set_nz(s.status_flags, s.index_x); bnd = 1'b1;
                  end
                  8'hA8: begin
                     s.index_y = s.acc; s.status_flags = set_nz(s.status_flags, s.acc);
                     bnd = 1'b1;
                  end
                  8'hAA: begin
                     s.index_x = s.acc; s.status_flags = set_nz(s.status_flags, s.acc);
                     bnd = 1'b1;
                  end
                  8'h8A: begin
                     s.acc = s.index_x; s.status_flags = set_nz(s.status_flags, s.acc);
                     bnd = 1'b1;
                  end
                  8'h98: begin
                     s.acc = s.index_y; s.status_flags = set_nz(s.status_flags, s.acc);
                     bnd = 1'b1;
                  end
                  8'h9A: begin s.stack_ptr = s.index_x; bnd = 1'b1; end
                  8'hBA: begin
                     s.index_x = s.stack_ptr;
                     s.status_flags = set_nz(s.status_flags, s.index_x); bnd = 1'b1;
                  end
                  8'h18: begin s.status_flags[0] = 1'b0; bnd = 1'b1; end
                  8'h38: begin s.status_flags[0] = 1'b1; bnd = 1'b1; end
                  8'h58: begin s.status_flags[2] = 1'b0; bnd = 1'b1; end
                  8'h78: begin s.status_flags[2] = 1'b1; bnd = 1'b1; end
                  8'hB8: begin s.status_flags[6] = 1'b0; bnd = 1'b1; end
                  8'hD8: begin s.status_flags[3] = 1'b0; bnd = 1'b1; end
                  8'hF8: begin s.status_flags[3] = 1'b1; bnd = 1'b1; end
                  8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
                     sr = shf({2'b01, d[7:5]}, s.acc, s.status_flags[0]);
                     s.status_flags[0] = sr[8];
                     s.acc = sr[7:0];
                     s.status_flags = set_nz(s.status_flags, s.acc);
                     bnd = 1'b1;
                  end
                  8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
                     r[0] = mk_rd(s.prog_counter); n = 3'd1; s.seq_phase = PH_BR;
                  end
                  default: begin
                     if (dc.mode != M_BAD) begin
                        r[0] = mk_rd(s.prog_counter); n = 3'd1; s.seq_phase = PH_OP1;
                     end else begin
                        bnd = 1'b1;
                     end
                  end
               endcase
            end
            PH_INT: begin
               r[0] = mk_wr({STACK_PAGE, s.stack_ptr}, s.prog_counter[15:8]);
               r[1] = mk_wr({STACK_PAGE, s.stack_ptr - 8'd1}, s.prog_counter[7:0]);
               r[2] = mk_wr({STACK_PAGE, s.stack_ptr - 8'd2},
                            (s.status_flags & 8'hEF) | 8'h20);
               s.stack_ptr = s.stack_ptr - 8'd3;
               s.status_flags[2] = 1'b1;
               r[3] = mk_rd(s.addr_temp);
               n = 3'd4;
               s.seq_phase = PH_VEC_LO;
            end
            PH_OP1: begin
               s.prog_counter = s.prog_counter + 16'd1;
               case (dc.mode)
                  M_IMM: begin s = do_read(s, dc.kind, d); bnd = 1'b1; end
                  M_ZP:  begin eff = 1'b1; ea = {8'h00, d}; end
                  M_ZPX: begin eff = 1'b1; ea = {8'h00, d + s.index_x}; end
                  M_ZPY: begin eff = 1'b1; ea = {8'h00, d + s.index_y}; end
                  M_ABS, M_ABX, M_ABY: begin
                     s.addr_temp = {8'h00, d};
                     r[0] = mk_rd(s.prog_counter); n = 3'd1; s.seq_phase = PH_OP2;
                  end
                  M_IZX, M_IZY: begin
                     s.addr_temp = {8'h00, (dc.mode == M_IZX) ? d + s.index_x : d};
                     r[0] = mk_rd(s.addr_temp); n = 3'd1; s.seq_phase = PH_PTR_LO;
                  end
                  default: bnd = 1'b1;
               endcase
            end
            PH_OP2: begin
               s.prog_counter = s.prog_counter + 16'd1;
               ea = {d, s.addr_temp[7:0]};
               if (dc.mode == M_ABX) ea = ea + {8'h00, s.index_x};
               if (dc.mode == M_ABY) ea = ea + {8'h00, s.index_y};
               eff = 1'b1;
            end
            PH_PTR_LO: begin
               s.addr_temp = {d, s.addr_temp[7:0]};
               r[0] = mk_rd({8'h00, s.addr_temp[7:0] + 8'd1}); n = 3'd1;
               s.seq_phase = PH_PTR_HI;
            end
            PH_PTR_HI: begin
               ea = {d, s.addr_temp[15:8]};
               if (dc.mode == M_IZY) ea = ea + {8'h00, s.index_y};
               eff = 1'b1;
            end
            PH_DATA: begin
               if (dc.kind >= K_ASL && dc.kind <= K_ROR) begin
                  sr = shf(dc.kind, d, s.status_flags[0]);
                  s.status_flags[0] = sr[8];
                  s.status_flags = set_nz(s.status_flags, sr[7:0]);
                  r[0] = mk_wr(s.addr_temp, sr[7:0]); n = 3'd1;
               end else if (dc.kind == K_DEC || dc.kind == K_INC) begin
                  t = (dc.kind == K_DEC) ? d - 8'd1 : d + 8'd1;
                  s.status_flags = set_nz(s.status_flags, t);
                  r[0] = mk_wr(s.addr_temp, t); n = 3'd1;
               end else begin
                  s = do_read(s, dc.kind, d);
               end
               bnd = 1'b1;
            end
            PH_J_LO: begin
               s.addr_temp = {8'h00, d};
               s.prog_counter = s.prog_counter + 16'd1;
               r[0] = mk_rd(s.prog_counter); n = 3'd1;
               s.seq_phase = PH_J_HI;
            end
            PH_J_HI: begin
               ea = {d, s.addr_temp[7:0]};
               if (s.opcode_latch == 8'h20) begin
                  r[0] = mk_wr({STACK_PAGE, s.stack_ptr}, s.prog_counter[15:8]);
                  r[1] = mk_wr({STACK_PAGE, s.stack_ptr - 8'd1}, s.prog_counter[7:0]);
                  n = 3'd2;
                  s.stack_ptr = s.stack_ptr - 8'd2;
                  s.prog_counter = ea;
                  bnd = 1'b1;
               end else if (s.opcode_latch == 8'h6C) begin
                  s.addr_temp = ea;
                  r[0] = mk_rd(ea); n = 3'd1;
                  s.seq_phase = PH_JI_LO;
               end else begin
                  s.prog_counter = ea;
                  bnd = 1'b1;
               end
            end
            PH_JI_LO: begin
               s.prog_counter[7:0] = d;
               r[0] = mk_rd({s.addr_temp[15:8], s.addr_temp[7:0] + 8'd1}); n = 3'd1;
               s.seq_phase = PH_JI_HI;
            end
            PH_JI_HI, PH_RTI_HI: begin
               s.prog_counter[15:8] = d;
               bnd = 1'b1;
            end
            PH_BR: begin
               case (s.opcode_latch[7:6])
                  2'd0:    taken = s.status_flags[7];
                  2'd1:    taken = s.status_flags[6];
                  2'd2:    taken = s.status_flags[0];
                  default: taken = s.status_flags[1];
               endcase
               s.prog_counter = s.prog_counter + 16'd1;
               if (taken == s.opcode_latch[5])
                  s.prog_counter = s.prog_counter + {{8{d[7]}}, d};
               bnd = 1'b1;
            end
            PH_PULL: begin
               if (s.opcode_latch == 8'h68) begin
                  s.acc = d; s.status_flags = set_nz(s.status_flags, d);
               end else begin
                  s.status_flags = d & 8'hCF;
               end
               bnd = 1'b1;
            end
            PH_RTS_LO, PH_RTI_LO: begin
               s.prog_counter[7:0] = d;
               s.stack_ptr = s.stack_ptr + 8'd1;
               r[0] = mk_rd({STACK_PAGE, s.stack_ptr}); n = 3'd1;
               s.seq_phase = (s.seq_phase == PH_RTS_LO) ? PH_RTS_HI : PH_RTI_HI;
            end
            PH_RTS_HI: begin
               s.prog_counter = {d, s.prog_counter[7:0]} + 16'd1;
               bnd = 1'b1;
            end
            PH_RTI_P: begin
               s.status_flags = d & 8'hCF;
               s.stack_ptr = s.stack_ptr + 8'd1;
               r[0] = mk_rd({STACK_PAGE, s.stack_ptr}); n = 3'd1;
               s.seq_phase = PH_RTI_LO;
            end
            default: bnd = 1'b1;
         endcase

         if (eff) begin
            if (dc.kind == K_STA || dc.kind == K_STX || dc.kind == K_STY) begin
               r[n[1:0]] = mk_wr(ea, (dc.kind == K_STA) ? s.acc :
                                 ((dc.kind == K_STX) ? s.index_x : s.index_y));
               n = n + 3'd1;
               bnd = 1'b1;
            end else begin
               s.addr_temp = ea;
               r[n[1:0]] = mk_rd(ea);
               n = n + 3'd1;
               s.seq_phase = PH_DATA;
            end
         end

         if (bnd) begin
            if (s.nmi_pending) begin
               s.nmi_pending = 1'b0;
               s.addr_temp = VEC_NMI;
               s.seq_phase = PH_INT;
            end else if (irq_level && !s.status_flags[2]) begin
               s.addr_temp = VEC_IRQ;
               s.seq_phase = PH_INT;
            end else begin
               s.seq_phase = PH_FETCH;
            end
            r[n[1:0]] = mk_rd(s.prog_counter);
            n = n + 3'd1;
         end
      end
      nxt_state = s;
      res       = r;
      res_count = n;
   end

endmodule

### rtl/mos6502_core_bus_stepper.sv
// 6502 core as a bus-cycle stepper. One transaction in (reset or read data)
// yields one to four bus accesses out, the read request last.
// A transaction is registered, stepped combinationally by m65_step and its accesses
// are unloaded from a four-entry output queue, one per cycle while rsp_tready is high.
// The next transaction is taken while the last access of the previous one is being
// handed out, so a step with one access sustains one transaction per clock unless the
// output stalls. Depends on m65_pkg, m65_step and the assert header.
module mos6502_core_bus_stepper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // read_data[7:0], irq_level[8], nmi_pulse[9]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // bus_address[15:0], write_data[23:16]
   output logic        rsp_tuser,   // bus_write
   output logic        rsp_tlast    // last
);
   import m65_pkg::*;
   `include "mos6502_core_bus_stepper_assert.svh"

   logic          in_valid_ff, in_valid_in;
   logic          in_op_ff;
   logic [7:0]    in_data_ff;
   logic          in_irq_ff;
   logic          in_nmi_ff;
   cpu_state_type cpu_ff, cpu_in;
   res_list_type  obuf_ff, obuf_in;
   logic [2:0]    ocnt_ff, ocnt_in;
   res_list_type  step_res;
   logic [2:0]    step_cnt;
   logic          pop;
   logic          load;
   logic          take;

   m65_step u_step (
      .cur_state (cpu_ff),
      .op        (in_op_ff),
      .read_data (in_data_ff),
      .irq_level (in_irq_ff),
      .nmi_pulse (in_nmi_ff),
      .nxt_state (cpu_in),
      .res       (step_res),
      .res_count (step_cnt)
   );

   assign rsp_tvalid = (ocnt_ff != 3'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign load       = in_valid_ff && (ocnt_ff == 3'd0 || (ocnt_ff == 3'd1 && pop));
   assign req_tready = !in_valid_ff || load;
   assign take       = req_tvalid && req_tready;

   assign rsp_tdata = {obuf_ff[0].write_data, obuf_ff[0].bus_address};
   assign rsp_tuser = obuf_ff[0].bus_write;
   assign rsp_tlast = obuf_ff[0].last;

   always_comb begin
      in_valid_in = take || (in_valid_ff && !load);
      obuf_in = obuf_ff;
      ocnt_in = ocnt_ff;
      if (load) begin
         obuf_in = step_res;
         ocnt_in = step_cnt;
      end else if (pop) begin
         obuf_in = {obuf_ff[3], obuf_ff[3:1]};
         ocnt_in = ocnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ocnt_ff     <= 3'd0;
         cpu_ff      <= CPU_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         ocnt_ff     <= ocnt_in;
         if (load) cpu_ff <= cpu_in;
      end
   end

   always_ff @(posedge clock) begin
      obuf_ff <= obuf_in;
      if (take) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata[7:0];
         in_irq_ff  <= req_tdata[8];
         in_nmi_ff  <= req_tdata[9];
      end
   end

   `M65_ASSERT_NOW(a_ocnt_range, clock, reset, 1'b1, ocnt_ff <= 3'd4, "queue overfilled")
   `M65_ASSERT_NEXT(a_load_fills, clock, reset, load, ocnt_ff != 3'd0, "step gave no access")
   `M65_ASSERT_NOW(a_last_final, clock, reset, rsp_tvalid && rsp_tlast, ocnt_ff == 3'd1,
      "last access not final")
   `M65_ASSERT_NOW(a_write_not_last, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tlast,
      "write marked last")

endmodule

### sim/tb.sv
// Testbench for mos6502_core_bus_stepper: drives bus-data transactions, predicts
// the bus accesses with a behavioral 6502 model and checks them in order.
// Depends on m65_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
   import m65_pkg::*;

   typedef struct packed {
      logic        op;
      logic [7:0]  rdata;
      logic        irq;
      logic        nmi;
   } bus_in_type;

   typedef struct packed {
      logic [15:0] addr;
      logic        wr;
      logic [7:0]  wdata;
      logic        lst;
   } access_type;

   typedef struct {
      bus_in_type  stim;
      logic        has_exp;
      logic [15:0] exp_addr;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   mos6502_core_bus_stepper DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p, cpu_ir;
   logic [15:0] cpu_pc, cpu_tmp;
   phase_type   cpu_ph;
   logic        cpu_nmi, irq_line;

   access_type  access_q[$];
   int          errors = 0;
   int          send_idle = 26, recv_idle = 72;
   bit          hold_rsp = 1'b0;
   int          idle_cycles = 0;
   int          n_items = 0, n_rsp = 0, n_wr = 0, n_int = 0;

   function automatic void cpu_reset();
      cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_sp = 8'hFF; cpu_pc = 0;
      cpu_p = 8'h04; cpu_ph = PH_VEC_LO; cpu_ir = 0; cpu_tmp = 0; cpu_nmi = 0;
   endfunction

   function automatic void put_rd(logic [15:0] a);
      access_q.push_back('{a, 1'b0, 8'h00, 1'b1});
   endfunction

   function automatic void put_wr(logic [15:0] a, logic [7:0] d);
      access_q.push_back('{a, 1'b1, d, 1'b0});
   endfunction

   function automatic void push_stack(logic [7:0] v);
      put_wr({8'h01, cpu_sp}, v);
      cpu_sp--;
   endfunction

   function automatic logic [15:0] pop_addr();
      cpu_sp++;
      return {8'h01, cpu_sp};
   endfunction

   function automatic void flag_nz(logic [7:0] v);
      cpu_p = {v[7], cpu_p[6:2], v == 8'h00, cpu_p[0]};
   endfunction

   function automatic void at_boundary();
      if (cpu_nmi) begin
         cpu_nmi = 0; cpu_tmp = VEC_NMI; cpu_ph = PH_INT; n_int++;
      end else if (irq_line && !cpu_p[2]) begin
         cpu_tmp = VEC_IRQ; cpu_ph = PH_INT; n_int++;
      end else
         cpu_ph = PH_FETCH;
      put_rd(cpu_pc);
   endfunction

   function automatic void adc(logic [7:0] m);
      logic [8:0] s;
      logic [7:0] r;
      s = cpu_a + m + cpu_p[0];
      r = s[7:0];
      cpu_p[0] = s[8];
      cpu_p[6] = (cpu_a[7] ^ r[7]) & (m[7] ^ r[7]);
      cpu_a = r;
      flag_nz(r);
   endfunction

   function automatic void cmp8(logic [7:0] a, logic [7:0] b);
      flag_nz(a - b);
      cpu_p[0] = a >= b;
   endfunction

   function automatic logic [7:0] rotate(logic [4:0] k, logic [7:0] v);
      logic [7:0] r;
      case (k)
         K_ASL: begin r = {v[6:0], 1'b0}; cpu_p[0] = v[7]; end
         K_ROL: begin r = {v[6:0], cpu_p[0]}; cpu_p[0] = v[7]; end
         K_LSR: begin r = {1'b0, v[7:1]}; cpu_p[0] = v[0]; end
         default: begin r = {cpu_p[0], v[7:1]}; cpu_p[0] = v[0]; end
      endcase
      flag_nz(r);
      return r;
   endfunction

   // opcode map: addressing mode and operation kind
   function automatic void opmap(logic [7:0] op, output mode_type md, output logic [4:0] k);
      logic [2:0] aaa, bbb;
      aaa = op[7:5];
      bbb = op[4:2];
      md = M_BAD;
      k = K_NONE;
      if (op[1:0] == 2'd1) begin
         k = {2'b00, aaa};
         case (bbb)
            0: md = M_IZX; 1: md = M_ZP; 2: md = op == 8'h89 ? M_BAD : M_IMM;
            3: md = M_ABS; 4: md = M_IZY; 5: md = M_ZPX; 6: md = M_ABY;
            default: md = M_ABX;
         endcase
      end else if (op[1:0] == 2'd2) begin
         k = K_ASL + aaa;
         case (bbb)
            0: md = op == 8'hA2 ? M_IMM : M_BAD;
            1: md = M_ZP;
            3: md = M_ABS;
            5: md = (aaa == 4 || aaa == 5) ? M_ZPY : M_ZPX;
            7: md = aaa == 5 ? M_ABY : (aaa == 4 ? M_BAD : M_ABX);
            default: md = M_BAD;
         endcase
      end else if (op[1:0] == 2'd0 && aaa != 0 && aaa != 2 && aaa != 3) begin
         case (aaa)
            1: k = K_BIT; 4: k = K_STY; 5: k = K_LDY; 6: k = K_CPY;
            default: k = K_CPX;
         endcase
         case (bbb)
            0: md = aaa >= 5 ? M_IMM : M_BAD;
            1: md = M_ZP;
            3: md = M_ABS;
            5: md = (aaa == 4 || aaa == 5) ? M_ZPX : M_BAD;
            7: md = aaa == 5 ? M_ABX : M_BAD;
            default: md = M_BAD;
         endcase
      end
   endfunction

   function automatic void read_op(logic [4:0] k, logic [7:0] m);
      case (k)
         K_ORA: begin cpu_a |= m; flag_nz(cpu_a); end
         K_AND: begin cpu_a &= m; flag_nz(cpu_a); end
         K_EOR: begin cpu_a ^= m; flag_nz(cpu_a); end
         K_ADC: adc(m);
         K_LDA: begin cpu_a = m; flag_nz(m); end
         K_CMP: cmp8(cpu_a, m);
         K_SBC: adc(~m);
         K_LDX: begin cpu_x = m; flag_nz(m); end
         K_BIT: cpu_p = {m[7:6], cpu_p[5:2], (cpu_a & m) == 0, cpu_p[0]};
         K_LDY: begin cpu_y = m; flag_nz(m); end
         K_CPY: cmp8(cpu_y, m);
         K_CPX: cmp8(cpu_x, m);
         default: ;
      endcase
   endfunction

   function automatic void to_target(logic [4:0] k, logic [15:0] ea);
      if (k == K_STA || k == K_STX || k == K_STY) begin
         put_wr(ea, k == K_STA ? cpu_a : (k == K_STX ? cpu_x : cpu_y));
         at_boundary();
      end else begin
         cpu_tmp = ea;
         put_rd(ea);
         cpu_ph = PH_DATA;
      end
   endfunction

   function automatic void do_fetch(logic [7:0] op);
      mode_type md;
      logic [4:0] k;
      cpu_ir = op;
      cpu_pc++;
      case (op)
         8'h00: begin
            cpu_pc++;
            push_stack(cpu_pc[15:8]);
            push_stack(cpu_pc[7:0]);
            push_stack(cpu_p | 8'h30);
            cpu_p[2] = 1;
            cpu_tmp = VEC_IRQ;
            put_rd(VEC_IRQ);
            cpu_ph = PH_VEC_LO;
            return;
         end
         8'h20, 8'h4C, 8'h6C: begin put_rd(cpu_pc); cpu_ph = PH_J_LO; return; end
         8'h40: begin put_rd(pop_addr()); cpu_ph = PH_RTI_P; return; end
         8'h60: begin put_rd(pop_addr()); cpu_ph = PH_RTS_LO; return; end
         8'h28, 8'h68: begin put_rd(pop_addr()); cpu_ph = PH_PULL; return; end
         8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
            put_rd(cpu_pc); cpu_ph = PH_BR; return;
         end
         8'h08: push_stack(cpu_p | 8'h30);
         8'h48: push_stack(cpu_a);
         8'h88: begin cpu_y--; flag_nz(cpu_y); end
         8'hC8: begin cpu_y++; flag_nz(cpu_y); end
         8'hCA: begin cpu_x--; flag_nz(cpu_x); end
         8'hE8: begin cpu_x++; flag_nz(cpu_x); end
         8'hA8: begin cpu_y = cpu_a; flag_nz(cpu_a); end
         8'hAA: begin cpu_x = cpu_a; flag_nz(cpu_a); end
         8'h8A: begin cpu_a = cpu_x; flag_nz(cpu_a); end
         8'h98: begin cpu_a = cpu_y; flag_nz(cpu_a); end
         8'h9A: cpu_sp = cpu_x;
         8'hBA: begin cpu_x = cpu_sp; flag_nz(cpu_x); end
         8'h18: cpu_p[0] = 0;
         8'h38: cpu_p[0] = 1;
         8'h58: cpu_p[2] = 0;
         8'h78: cpu_p[2] = 1;
         8'hB8: cpu_p[6] = 0;
         8'hD8: cpu_p[3] = 0;
         8'hF8: cpu_p[3] = 1;
         8'h0A, 8'h2A, 8'h4A, 8'h6A: cpu_a = rotate(K_ASL + op[7:5], cpu_a);
         default: begin
            opmap(op, md, k);
            if (md != M_BAD) begin put_rd(cpu_pc); cpu_ph = PH_OP1; return; end
         end
      endcase
      at_boundary();
   endfunction

   function automatic void predict_step(bus_in_type t);
      mode_type md;
      logic [4:0] k;
      logic [15:0] ea;
      logic [7:0] d, r;
      logic taken;
      d = t.rdata;
      irq_line = t.irq;
      if (!t.op) begin
         cpu_reset();
         put_rd(VEC_RES);
         return;
      end
      if (t.nmi) cpu_nmi = 1;
      opmap(cpu_ir, md, k);
      case (cpu_ph)
         PH_VEC_LO: begin
            cpu_pc[7:0] = d;
            put_rd((cpu_tmp == VEC_NMI || cpu_tmp == VEC_IRQ) ? cpu_tmp + 16'd1 : 16'hFFFD);
            cpu_ph = PH_VEC_HI;
         end
         PH_VEC_HI: begin cpu_pc[15:8] = d; at_boundary(); end
         PH_FETCH: do_fetch(d);
         PH_INT: begin
            push_stack(cpu_pc[15:8]);
            push_stack(cpu_pc[7:0]);
            push_stack((cpu_p & 8'hEF) | 8'h20);
            cpu_p[2] = 1;
            put_rd(cpu_tmp);
            cpu_ph = PH_VEC_LO;
         end
         PH_OP1: begin
            cpu_pc++;
            case (md)
               M_IMM: begin read_op(k, d); at_boundary(); end
               M_ZP: to_target(k, {8'h00, d});
               M_ZPX: to_target(k, {8'h00, d + cpu_x});
               M_ZPY: to_target(k, {8'h00, d + cpu_y});
               M_ABS, M_ABX, M_ABY: begin
                  cpu_tmp = {8'h00, d}; put_rd(cpu_pc); cpu_ph = PH_OP2;
               end
               M_IZX: begin
                  cpu_tmp = {8'h00, d + cpu_x}; put_rd(cpu_tmp); cpu_ph = PH_PTR_LO;
               end
               M_IZY: begin cpu_tmp = {8'h00, d}; put_rd(cpu_tmp); cpu_ph = PH_PTR_LO; end
               default: at_boundary();
            endcase
         end
         PH_OP2: begin
            cpu_pc++;
            ea = {d, cpu_tmp[7:0]};
            if (md == M_ABX) ea += cpu_x;
            if (md == M_ABY) ea += cpu_y;
            to_target(k, ea);
         end
         PH_PTR_LO: begin
            cpu_tmp[15:8] = d;
            put_rd({8'h00, cpu_tmp[7:0] + 8'd1});
            cpu_ph = PH_PTR_HI;
         end
         PH_PTR_HI: begin
            ea = {d, cpu_tmp[15:8]};
            if (md == M_IZY) ea += cpu_y;
            to_target(k, ea);
         end
         PH_DATA: begin
            if (k >= K_ASL && k <= K_ROR) put_wr(cpu_tmp, rotate(k, d));
            else if (k == K_DEC || k == K_INC) begin
               r = k == K_DEC ? d - 1 : d + 1;
               flag_nz(r);
               put_wr(cpu_tmp, r);
            end else read_op(k, d);
            at_boundary();
         end
         PH_J_LO: begin
            cpu_tmp = {8'h00, d}; cpu_pc++; put_rd(cpu_pc); cpu_ph = PH_J_HI;
         end
         PH_J_HI: begin
            ea = {d, cpu_tmp[7:0]};
            if (cpu_ir == 8'h20) begin
               push_stack(cpu_pc[15:8]);
               push_stack(cpu_pc[7:0]);
               cpu_pc = ea;
               at_boundary();
            end else if (cpu_ir == 8'h6C) begin
               cpu_tmp = ea; put_rd(ea); cpu_ph = PH_JI_LO;
            end else begin
               cpu_pc = ea; at_boundary();
            end
         end
         PH_JI_LO: begin
            cpu_pc[7:0] = d;
            put_rd({cpu_tmp[15:8], cpu_tmp[7:0] + 8'd1});
            cpu_ph = PH_JI_HI;
         end
         PH_JI_HI, PH_RTI_HI: begin cpu_pc[15:8] = d; at_boundary(); end
         PH_BR: begin
            case (cpu_ir[7:6])
               0: taken = cpu_p[7]; 1: taken = cpu_p[6]; 2: taken = cpu_p[0];
               default: taken = cpu_p[1];
            endcase
            cpu_pc++;
            if (taken == cpu_ir[5]) cpu_pc += {{8{d[7]}}, d};
            at_boundary();
         end
         PH_PULL: begin
            if (cpu_ir == 8'h68) begin cpu_a = d; flag_nz(d); end
            else cpu_p = d & 8'hCF;
            at_boundary();
         end
         PH_RTS_LO, PH_RTI_LO: begin
            cpu_pc[7:0] = d;
            put_rd(pop_addr());
            cpu_ph = cpu_ph == PH_RTS_LO ? PH_RTS_HI : PH_RTI_HI;
         end
         PH_RTS_HI: begin cpu_pc = {d, cpu_pc[7:0]} + 16'd1; at_boundary(); end
         PH_RTI_P: begin
            cpu_p = d & 8'hCF; put_rd(pop_addr()); cpu_ph = PH_RTI_LO;
         end
         default: at_boundary();
      endcase
   endfunction

   task automatic send_item(bus_in_type t);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= t.op;
      req_tdata  <= {6'b0, t.nmi, t.irq, t.rdata};
      predict_step(t);
      n_items++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // weighted opcode stream: mostly documented instructions
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      b = $urandom;
      if (cpu_ph == PH_FETCH && $urandom_range(99) < 80) begin
         mode_type md;
         logic [4:0] k;
         do begin
            b = $urandom;
            opmap(b, md, k);
         end while (md == M_BAD && !(b[3:0] == 4'h8 || b[3:0] == 4'hA || b == 8'h00
                    || b == 8'h20 || b == 8'h4C || b == 8'h6C || b == 8'h40
                    || b == 8'h60 || b[4:0] == 5'h10));
      end
      return b;
   endfunction

   always @(posedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      access_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsp++;
         if (access_q.size() == 0) begin
            $error("unexpected access addr=%h", rsp_tdata[15:0]);
            errors++;
         end else begin
            e = access_q.pop_front();
            if (e.wr) n_wr++;
            if (rsp_tdata[15:0] !== e.addr) begin
               $error("bus_address exp %h got %h", e.addr, rsp_tdata[15:0]); errors++;
            end
            if (rsp_tuser !== e.wr) begin
               $error("bus_write exp %b got %b", e.wr, rsp_tuser); errors++;
            end
            if (rsp_tdata[23:16] !== e.wdata) begin
               $error("write_data exp %h got %h", e.wdata, rsp_tdata[23:16]); errors++;
            end
            if (rsp_tlast !== e.lst) begin
               $error("last exp %b got %b", e.lst, rsp_tlast); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("mos6502_core_bus_stepper: mismatch");
         $finish;
      end
   end

   // directed: reset, vectors, key instructions, interrupts
   dir_row_type dir_rows[] = '{
      '{'{1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, 16'hFFFC},
      '{'{1'b1, 8'h00, 1'b0, 1'b0}, 1'b1, 16'hFFFD},
      '{'{1'b1, 8'h80, 1'b0, 1'b0}, 1'b1, 16'h8000},
      '{'{1'b1, 8'hA9, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'hFF, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h69, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h01, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h24, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'hC0, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'hFF, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h00, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h00, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h12, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h34, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h58, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'hEA, 1'b1, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h00, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h00, 1'b0, 1'b1}, 1'b0, 16'h0},
      '{'{1'b1, 8'hFF, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h6C, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'hFF, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h12, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h02, 1'b0, 1'b0}, 1'b0, 16'h0},
      '{'{1'b1, 8'h40, 1'b0, 1'b0}, 1'b0, 16'h0}
   };

   initial begin
      int lead;
      bus_in_type t;
      cpu_reset();
      irq_line = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         lead = access_q.size();
         send_item(dir_rows[i].stim);
         if (dir_rows[i].has_exp && access_q[lead].addr !== dir_rows[i].exp_addr) begin
            $error("bus_address exp %h got %h", dir_rows[i].exp_addr, access_q[lead].addr);
            errors++;
         end
      end
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = phase == 0 ? 26 : (phase == 1 ? 72 : 0);
         recv_idle = phase == 0 ? 72 : (phase == 1 ? 26 : 0);
         for (int n = 0; n < 155; n++) begin
            if (phase == 2 && n == 10) begin
               fork
                  begin
                     hold_rsp = 1'b1;
                     repeat (60) @(posedge clock);
                     hold_rsp = 1'b0;
                  end
               join_none
            end
            t.op = $urandom_range(199) != 0;
            t.rdata = pick_byte();
            t.irq = $urandom_range(99) < 8;
            t.nmi = $urandom_range(99) < 2;
            send_item(t);
         end
      end
      req_tvalid <= 1'b0;
      while (access_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d transactions, %0d accesses (%0d writes), %0d interrupt entries",
               n_items, n_rsp, n_wr, n_int);
      if (errors == 0 && access_q.size() == 0)
         $display("mos6502_core_bus_stepper: match");
      else
         $display("mos6502_core_bus_stepper: mismatch");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/m65_pkg.sv
rtl/m65_step.sv
rtl/mos6502_core_bus_stepper.sv
sim/tb.sv
